### sv/svpwm_pkg.sv
`default_nettype none
package svpwm_pkg;

	localparam int unsigned UsWidth = 16;

	localparam logic [UsWidth-1:0] FramePeriodReset = 16'd20000;
	localparam logic [UsWidth-1:0] MinPulseReset    = 16'd500;
	localparam logic [UsWidth-1:0] MaxPulseReset    = 16'd2500;
	localparam logic [UsWidth-1:0] SlewStepReset    = 16'd25;

	typedef enum logic [1:0] {
		CFG_FRAME_PERIOD = 2'd0,
		CFG_MIN_PULSE    = 2'd1,
		CFG_MAX_PULSE    = 2'd2,
		CFG_SLEW_STEP    = 2'd3
	} cfg_index_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_SET  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [UsWidth-1:0] frame_period;
		logic [UsWidth-1:0] min_pulse;
		logic [UsWidth-1:0] max_pulse;
		logic [UsWidth-1:0] slew_step;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic               channel;
		logic [UsWidth-1:0] pulse_us;
	} item_t;

	// Move cur toward tgt by at most step; a zero on either side jumps to tgt.
	function automatic logic [UsWidth-1:0] slew_toward(
		input logic [UsWidth-1:0] cur,
		input logic [UsWidth-1:0] tgt,
		input logic [UsWidth-1:0] step
	);
		logic [UsWidth:0]   up;
		logic [UsWidth-1:0] down;
		logic [UsWidth-1:0] res;
		up   = {1'b0, cur} + {1'b0, step};
		down = cur - step;
		if (cur == '0 || tgt == '0) begin
			res = tgt;
		end else if ({1'b0, tgt} > up) begin
			res = up[UsWidth-1:0];
		end else if (cur > step && tgt < down) begin
			res = down;
		end else begin
			res = tgt;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### sv/svpwm_cfg_regs.sv
`default_nettype none
module svpwm_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [svpwm_pkg::UsWidth-1:0]   cfg_data,
	output svpwm_pkg::cfg_t                      cfg
);
	import svpwm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_period <= FramePeriodReset;
			cfg_q.min_pulse    <= MinPulseReset;
			cfg_q.max_pulse    <= MaxPulseReset;
			cfg_q.slew_step    <= SlewStepReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FRAME_PERIOD: cfg_q.frame_period <= cfg_data;
				CFG_MIN_PULSE:    cfg_q.min_pulse    <= cfg_data;
				CFG_MAX_PULSE:    cfg_q.max_pulse    <= cfg_data;
				CFG_SLEW_STEP:    cfg_q.slew_step    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/svpwm_in_reg.sv
`default_nettype none
module svpwm_in_reg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire svpwm_pkg::item_t                item_in,
	input  wire logic                            advance,
	output logic                                 valid_s1,
	output svpwm_pkg::item_t                     item_s1
);
	import svpwm_pkg::*;

	logic take;

	// Hold the staged item while it cannot move on.
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

endmodule
`default_nettype wire

### sv/svpwm_core.sv
`default_nettype none
module svpwm_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire svpwm_pkg::cfg_t                 cfg,
	input  wire logic                            valid_s1,
	input  wire svpwm_pkg::item_t                item_s1,
	output logic                                 advance,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 pin_first,
	output logic                                 pin_second,
	output logic [svpwm_pkg::UsWidth-1:0]        target_first,
	output logic [svpwm_pkg::UsWidth-1:0]        target_second,
	output logic [svpwm_pkg::UsWidth-1:0]        width_first,
	output logic [svpwm_pkg::UsWidth-1:0]        width_second
);
	import svpwm_pkg::*;

	logic [UsWidth-1:0] target_q [2];
	logic [UsWidth-1:0] width_q  [2];
	logic               pin_q    [2];
	logic [UsWidth-1:0] frame_q;
	logic               out_valid_q;

	logic [UsWidth-1:0] clamped;
	logic [UsWidth-1:0] width_nxt [2];
	logic               pin_nxt   [2];
	logic [UsWidth:0]   frame_inc;
	logic [UsWidth-1:0] frame_nxt;
	logic               commit;

	assign advance = !out_valid_q || !out_stall;
	assign commit  = valid_s1 && advance;

	always_comb begin
		clamped = item_s1.pulse_us;
		if (clamped < cfg.min_pulse) begin
			clamped = cfg.min_pulse;
		end
		if (clamped > cfg.max_pulse) begin
			clamped = cfg.max_pulse;
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			width_nxt[i] = (frame_q == '0)
				? slew_toward(width_q[i], target_q[i], cfg.slew_step) : width_q[i];
			pin_nxt[i] = (width_nxt[i] != '0) && (frame_q < width_nxt[i]);
		end
		frame_inc = {1'b0, frame_q} + {{UsWidth{1'b0}}, 1'b1};
		frame_nxt = (frame_inc >= {1'b0, cfg.frame_period}) ? '0 : frame_inc[UsWidth-1:0];
	end

	// State registers double as the result register: they only move on commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			frame_q     <= '0;
			for (int i = 0; i < 2; i++) begin
				target_q[i] <= '0;
				width_q[i]  <= '0;
				pin_q[i]    <= 1'b0;
			end
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (commit) begin
				if (kind_t'(item_s1.kind) == KIND_SET) begin
					target_q[item_s1.channel] <= clamped;
				end else begin
					frame_q <= frame_nxt;
					for (int i = 0; i < 2; i++) begin
						width_q[i] <= width_nxt[i];
						pin_q[i]   <= pin_nxt[i];
					end
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pin_first     = pin_q[0];
	assign pin_second    = pin_q[1];
	assign target_first  = target_q[0];
	assign target_second = target_q[1];
	assign width_first   = width_q[0];
	assign width_second  = width_q[1];

endmodule
`default_nettype wire

### sv/servo_pwm_slew_limiter.sv
// Two-channel servo pulse generator with a per-frame slew limit.
//
// Input channel (in_valid / in_stall): each transfer is either a one
// microsecond tick (kind = 0) or a target update for one channel
// (kind = 1, channel, pulse_us). Every accepted item yields exactly one
// result on the output channel (out_valid / out_stall) with both pin
// levels, both clamped targets and both current output widths.
// A result passes through the input register, which the transfer loads,
// and then the state/result register, which loads once the core can advance.
// Throughput: one item per cycle while the receiver does not stall; each
// accepted tick updates the frame counter and width registers.
// When the receiver stalls, the result holds; one more item waits in the
// input register, and in_stall rises only once that register is full.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
// frame period, the clamp limits and the slew step; cfg_ready is always
// high. Write it only while no item is in flight.
// Reset (arst_n low): targets, widths, pins and frame counter clear to
// zero, registers take their defaults (20000, 500, 2500, 25 us) and both
// channels drop their valid.
`default_nettype none
module servo_pwm_slew_limiter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            kind,
	input  wire logic                            channel,
	input  wire logic [svpwm_pkg::UsWidth-1:0]   pulse_us,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 pin_first,
	output logic                                 pin_second,
	output logic [svpwm_pkg::UsWidth-1:0]        target_first,
	output logic [svpwm_pkg::UsWidth-1:0]        target_second,
	output logic [svpwm_pkg::UsWidth-1:0]        width_first,
	output logic [svpwm_pkg::UsWidth-1:0]        width_second,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [svpwm_pkg::UsWidth-1:0]   cfg_data
);
	import svpwm_pkg::*;

	cfg_t  cfg;
	item_t item_in;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;

	// Bundle the input fields into one item.
	assign item_in.kind     = kind;
	assign item_in.channel  = channel;
	assign item_in.pulse_us = pulse_us;

	svpwm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Hold one accepted item until the core can take it.
	svpwm_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Clamp, slew, count and drive pins; state registers form the result.
	svpwm_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pin_first     (pin_first),
		.pin_second    (pin_second),
		.target_first  (target_first),
		.target_second (target_second),
		.width_first   (width_first),
		.width_second  (width_second)
	);

endmodule
`default_nettype wire

### sv/svpwm_checker.sv
`default_nettype none
module svpwm_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_stall,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic                            pin_first,
	input  wire logic                            pin_second,
	input  wire logic [svpwm_pkg::UsWidth-1:0]   width_first,
	input  wire logic [svpwm_pkg::UsWidth-1:0]   width_second
);
	import svpwm_pkg::*;

	// Stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(width_first) &&
		$stable(width_second) && $stable(pin_first) && $stable(pin_second))
		else $error("stalled result changed");

	// Backpressure only when the result register is full and stalled.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// A pin can only be high with a nonzero width.
	a_pin_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pin_first |-> width_first != '0)
		else $error("channel 0 pin high with zero width");

	a_pin_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pin_second |-> width_second != '0)
		else $error("channel 1 pin high with zero width");

endmodule

bind servo_pwm_slew_limiter svpwm_checker u_svpwm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.pin_first    (pin_first),
	.pin_second   (pin_second),
	.width_first  (width_first),
	.width_second (width_second)
);
`default_nettype wire
